### sv/crtc_vrt_pkg.sv
package crtc_vrt_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int PADDR_W       = 5;

    localparam logic [2:0] REG_VTOTAL    = 3'd0;
    localparam logic [2:0] REG_VDISP     = 3'd1;
    localparam logic [2:0] REG_VSYNC_ROW = 3'd2;
    localparam logic [2:0] REG_VSYNC_LN  = 3'd3;
    localparam logic [2:0] REG_CHAR_HM1  = 3'd4;
    localparam logic [2:0] REG_VCTL      = 3'd5;
    localparam logic [2:0] REG_START     = 3'd6;
    localparam logic [2:0] REG_STRIDE    = 3'd7;

    localparam logic [7:0]  VTOTAL_RST    = 8'd39;
    localparam logic [7:0]  VDISP_RST     = 8'd25;
    localparam logic [7:0]  VSYNC_ROW_RST = 8'd0;
    localparam logic [3:0]  VSYNC_LN_RST  = 4'd0;
    localparam logic [4:0]  CHAR_HM1_RST  = 5'd7;
    localparam logic [6:0]  VCTL_RST      = 7'd0;
    localparam logic [31:0] START_RST     = 32'd0;
    localparam logic [8:0]  STRIDE_RST    = 9'd102;

    localparam int VCTL_SLOW_BLINK = 5;
    localparam int VCTL_BITMAP     = 6;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_BITMAP = 2'd1,
        MODE_IDLE   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0]  vtotal;
        logic [7:0]  vdisp;
        logic [7:0]  vsync_row;
        logic [3:0]  vsync_lines;
        logic [4:0]  char_hm1;
        logic [6:0]  vctl;
        logic [31:0] start;
        logic [8:0]  stride;
    } cfg_t;

    function automatic mode_t pick_mode(input logic bitmap, input logic [4:0] dlc,
                                        input logic [4:0] ch);
        mode_t m;
        m = bitmap ? MODE_BITMAP : MODE_TEXT;
        if (dlc > ch)
        begin
            m = MODE_IDLE;
        end
        return m;
    endfunction

endpackage

### sv/crtc_vrt_regs.sv
module crtc_vrt_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crtc_vrt_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output crtc_vrt_pkg::cfg_t                  cfg
);

    crtc_vrt_pkg::cfg_t cfg_reg;
    logic               wr_en;
    logic [2:0]         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vtotal      <= crtc_vrt_pkg::VTOTAL_RST;
            cfg_reg.vdisp       <= crtc_vrt_pkg::VDISP_RST;
            cfg_reg.vsync_row   <= crtc_vrt_pkg::VSYNC_ROW_RST;
            cfg_reg.vsync_lines <= crtc_vrt_pkg::VSYNC_LN_RST;
            cfg_reg.char_hm1    <= crtc_vrt_pkg::CHAR_HM1_RST;
            cfg_reg.vctl        <= crtc_vrt_pkg::VCTL_RST;
            cfg_reg.start       <= crtc_vrt_pkg::START_RST;
            cfg_reg.stride      <= crtc_vrt_pkg::STRIDE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                crtc_vrt_pkg::REG_VTOTAL:    cfg_reg.vtotal      <= pwdata[7:0];
                crtc_vrt_pkg::REG_VDISP:     cfg_reg.vdisp       <= pwdata[7:0];
                crtc_vrt_pkg::REG_VSYNC_ROW: cfg_reg.vsync_row   <= pwdata[7:0];
                crtc_vrt_pkg::REG_VSYNC_LN:  cfg_reg.vsync_lines <= pwdata[3:0];
                crtc_vrt_pkg::REG_CHAR_HM1:  cfg_reg.char_hm1    <= pwdata[4:0];
                crtc_vrt_pkg::REG_VCTL:      cfg_reg.vctl        <= pwdata[6:0];
                crtc_vrt_pkg::REG_START:     cfg_reg.start       <= pwdata;
                crtc_vrt_pkg::REG_STRIDE:    cfg_reg.stride      <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            crtc_vrt_pkg::REG_VTOTAL:    prdata = {24'd0, cfg_reg.vtotal};
            crtc_vrt_pkg::REG_VDISP:     prdata = {24'd0, cfg_reg.vdisp};
            crtc_vrt_pkg::REG_VSYNC_ROW: prdata = {24'd0, cfg_reg.vsync_row};
            crtc_vrt_pkg::REG_VSYNC_LN:  prdata = {28'd0, cfg_reg.vsync_lines};
            crtc_vrt_pkg::REG_CHAR_HM1:  prdata = {27'd0, cfg_reg.char_hm1};
            crtc_vrt_pkg::REG_VCTL:      prdata = {25'd0, cfg_reg.vctl};
            crtc_vrt_pkg::REG_START:     prdata = cfg_reg.start;
            crtc_vrt_pkg::REG_STRIDE:    prdata = {23'd0, cfg_reg.stride};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

### sv/crtc_vertical_raster_timing_top.sv
// channel   | signals                              | moves
// ----------+--------------------------------------+--------------------------------
// input     | in_valid, in_ready, line_tick        | one item per raster line
// output    | out_valid, out_ready, result fields  | line state after each item
// config    | psel, penable, pwrite, paddr, pwdata | apb writes, prdata reads back
//
// one item a cycle while out_ready is high; each item is held in the input register
// and its result is registered into the line state registers when it advances
// the line state registers are the result register and update only when it is free
// or being taken, so a stalled result holds while one further item waits in the input
// register; reset clears all counters and flags, mode resets to idle
module crtc_vertical_raster_timing_top #(
    parameter int ADDR_BITS = crtc_vrt_pkg::ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crtc_vrt_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                line_tick,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          raster_mode,
    output logic                                display_active,
    output logic                                in_vsync,
    output logic                                frame_start,
    output logic                                blink_phase,
    output logic [15:0]                         screen_address,
    output logic [15:0]                         attribute_address,
    output logic [15:0]                         char_offset,
    output logic [15:0]                         bitmap_offset,
    output logic [4:0]                          char_scan_line,
    output logic                                repaint_request
);

    crtc_vrt_pkg::cfg_t cfg;

    crtc_vrt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic s1_valid_reg, s1_tick_reg;
    logic out_valid_reg;
    logic advance;

    logic [4:0]           row_line_count_reg, row_line_count_next;
    logic [7:0]           row_count_reg, row_count_next;
    logic                 vsync_active_reg, vsync_active_next;
    logic [3:0]           vsync_count_reg, vsync_count_next;
    logic [7:0]           frame_count_reg, frame_count_next;
    logic                 blink_state_reg, blink_state_next;
    logic                 enable_flag_reg, enable_flag_next;
    logic                 drawing_reg, drawing_next;
    logic                 draw_done_reg, draw_done_next;
    logic                 priming_reg, priming_next;
    logic [4:0]           draw_line_count_reg, draw_line_count_next;
    logic [ADDR_BITS-1:0] char_counter_reg, char_counter_next;
    logic [ADDR_BITS-1:0] bitmap_counter_reg, bitmap_counter_next;
    logic [ADDR_BITS-1:0] screen_latch_reg, screen_latch_next;
    logic [ADDR_BITS-1:0] attribute_latch_reg, attribute_latch_next;
    logic [ADDR_BITS-1:0] previous_screen_reg, previous_screen_next;
    logic [ADDR_BITS-1:0] previous_attribute_reg, previous_attribute_next;
    crtc_vrt_pkg::mode_t  mode_reg, mode_next;
    logic                 repaint_flag_reg, repaint_flag_next;
    logic                 frame_start_reg, frame_start_next;

    logic [4:0]           ch;
    logic                 do_latch;
    logic [ADDR_BITS-1:0] stride_ext;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign ch       = cfg.char_hm1;
    assign stride_ext = ADDR_BITS'(cfg.stride);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_tick_reg <= line_tick;
        end
    end

    always_comb
    begin
        row_line_count_next     = row_line_count_reg;
        row_count_next          = row_count_reg;
        vsync_active_next       = vsync_active_reg;
        vsync_count_next        = vsync_count_reg;
        frame_count_next        = frame_count_reg;
        blink_state_next        = blink_state_reg;
        enable_flag_next        = enable_flag_reg;
        drawing_next            = drawing_reg;
        draw_done_next          = draw_done_reg;
        priming_next            = priming_reg;
        draw_line_count_next    = draw_line_count_reg;
        char_counter_next       = char_counter_reg;
        bitmap_counter_next     = bitmap_counter_reg;
        screen_latch_next       = screen_latch_reg;
        attribute_latch_next    = attribute_latch_reg;
        previous_screen_next    = previous_screen_reg;
        previous_attribute_next = previous_attribute_reg;
        mode_next               = mode_reg;
        repaint_flag_next       = repaint_flag_reg;
        frame_start_next        = 1'b0;
        do_latch                = 1'b0;

        if (s1_tick_reg)
        begin
            if (row_line_count_reg == ch)
            begin
                row_line_count_next = 5'd0;
                if (ch != 5'd0)
                begin
                    row_count_next = row_count_reg + 8'd1;
                end
                if (vsync_active_reg)
                begin
                    vsync_count_next = vsync_count_reg + 4'd1;
                    if (vsync_count_next == cfg.vsync_lines)
                    begin
                        vsync_active_next = 1'b0;
                        frame_start_next  = 1'b1;
                        frame_count_next  = frame_count_reg + 8'd1;
                        blink_state_next  = cfg.vctl[crtc_vrt_pkg::VCTL_SLOW_BLINK]
                                            ? frame_count_next[4] : frame_count_next[3];
                        repaint_flag_next = 1'b0;
                        if (drawing_reg)
                        begin
                            mode_next = crtc_vrt_pkg::pick_mode(
                                cfg.vctl[crtc_vrt_pkg::VCTL_BITMAP],
                                draw_line_count_reg, ch);
                        end
                    end
                end
                if (row_count_next == 8'd1)
                begin
                    enable_flag_next = 1'b1;
                    mode_next = crtc_vrt_pkg::pick_mode(
                        cfg.vctl[crtc_vrt_pkg::VCTL_BITMAP], draw_line_count_reg, ch);
                end
                if (row_count_next > cfg.vdisp)
                begin
                    enable_flag_next = 1'b0;
                    mode_next        = crtc_vrt_pkg::MODE_IDLE;
                end
                if (row_count_next > cfg.vtotal)
                begin
                    row_count_next      = 8'd0;
                    row_line_count_next = 5'd0;
                    priming_next        = 1'b1;
                    if (!draw_done_reg)
                    begin
                        do_latch = 1'b1;
                    end
                    draw_done_next = 1'b1;
                end
                if (row_count_next == cfg.vsync_row)
                begin
                    vsync_active_next = 1'b1;
                    vsync_count_next  = 4'd1;
                    mode_next         = crtc_vrt_pkg::MODE_IDLE;
                end
            end
            else
            begin
                row_line_count_next = row_line_count_reg + 5'd1;
            end

            // end of display rows, latch the start addresses
            if (({1'b0, row_count_next} == ({1'b0, cfg.vdisp} + 9'd1))
                && (row_line_count_next == 5'd1))
            begin
                drawing_next   = 1'b0;
                draw_done_next = 1'b1;
                do_latch       = 1'b1;
            end

            if (do_latch)
            begin
                screen_latch_next    = cfg.start[16 +: ADDR_BITS];
                attribute_latch_next = cfg.start[ADDR_BITS-1:0];
                if ((previous_screen_reg != screen_latch_next)
                    || (previous_attribute_reg != attribute_latch_next))
                begin
                    repaint_flag_next       = 1'b1;
                    previous_screen_next    = screen_latch_next;
                    previous_attribute_next = attribute_latch_next;
                end
                char_counter_next   = '0;
                bitmap_counter_next = '0;
            end

            if (priming_next)
            begin
                if ((row_count_next == 8'd0) && (row_line_count_next == 5'd0))
                begin
                    draw_line_count_next = cfg.vctl[4:0];
                end
                else if (draw_line_count_reg == ch)
                begin
                    draw_line_count_next = 5'd0;
                    priming_next         = 1'b0;
                    drawing_next         = 1'b1;
                end
                else
                begin
                    draw_line_count_next = draw_line_count_reg + 5'd1;
                end
            end
            else if (drawing_next)
            begin
                if (draw_line_count_reg == ch)
                begin
                    draw_line_count_next = 5'd0;
                    char_counter_next    = char_counter_next + stride_ext;
                end
                else
                begin
                    draw_line_count_next = draw_line_count_reg + 5'd1;
                end
                bitmap_counter_next = bitmap_counter_next + stride_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_line_count_reg     <= 5'd0;
            row_count_reg          <= 8'd0;
            vsync_active_reg       <= 1'b0;
            vsync_count_reg        <= 4'd0;
            frame_count_reg        <= 8'd0;
            blink_state_reg        <= 1'b0;
            enable_flag_reg        <= 1'b0;
            drawing_reg            <= 1'b0;
            draw_done_reg          <= 1'b0;
            priming_reg            <= 1'b0;
            draw_line_count_reg    <= 5'd0;
            char_counter_reg       <= '0;
            bitmap_counter_reg     <= '0;
            screen_latch_reg       <= '0;
            attribute_latch_reg    <= '0;
            previous_screen_reg    <= '0;
            previous_attribute_reg <= '0;
            mode_reg               <= crtc_vrt_pkg::MODE_IDLE;
            repaint_flag_reg       <= 1'b0;
            frame_start_reg        <= 1'b0;
        end
        else if (advance)
        begin
            row_line_count_reg     <= row_line_count_next;
            row_count_reg          <= row_count_next;
            vsync_active_reg       <= vsync_active_next;
            vsync_count_reg        <= vsync_count_next;
            frame_count_reg        <= frame_count_next;
            blink_state_reg        <= blink_state_next;
            enable_flag_reg        <= enable_flag_next;
            drawing_reg            <= drawing_next;
            draw_done_reg          <= draw_done_next;
            priming_reg            <= priming_next;
            draw_line_count_reg    <= draw_line_count_next;
            char_counter_reg       <= char_counter_next;
            bitmap_counter_reg     <= bitmap_counter_next;
            screen_latch_reg       <= screen_latch_next;
            attribute_latch_reg    <= attribute_latch_next;
            previous_screen_reg    <= previous_screen_next;
            previous_attribute_reg <= previous_attribute_next;
            mode_reg               <= mode_next;
            repaint_flag_reg       <= repaint_flag_next;
            frame_start_reg        <= frame_start_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign raster_mode       = mode_reg;
    assign display_active    = enable_flag_reg;
    assign in_vsync          = vsync_active_reg;
    assign frame_start       = frame_start_reg;
    assign blink_phase       = blink_state_reg;
    assign screen_address    = 16'(screen_latch_reg);
    assign attribute_address = 16'(attribute_latch_reg);
    assign char_offset       = 16'(char_counter_reg);
    assign bitmap_offset     = 16'(bitmap_counter_reg);
    assign char_scan_line    = draw_line_count_reg;
    assign repaint_request   = repaint_flag_reg;

endmodule
